/* hw/rtl/clb_pkg.sv */
// ----------------------------------------------------------------------------
// clb_pkg
// Shared types and constants for the cell-list binning block.
// ----------------------------------------------------------------------------
package clb_pkg;

  // Field and register widths
  localparam int unsigned LEN_W   = 23;
  localparam int unsigned GRID_W  = 13;
  localparam int unsigned POS_W   = 24;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned CFG_W   = 3;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned CELL_W  = 12;
  localparam int unsigned SLOT_W  = 6;

  // Doubled-scale datapath widths
  localparam int unsigned CMP_W   = 27;  // signed compare width
  localparam int unsigned DIV_W   = 24;  // numerator, divisor and quotient
  localparam int unsigned QS_W    = 25;  // signed quotient
  localparam int unsigned MA_W    = 38;  // signed multiplicand
  localparam int unsigned MP_W    = 51;  // signed product
  localparam int unsigned SUM_W   = 52;  // signed linear cell

  // Membrane tolerance at doubled scale
  localparam int MEMB_TOL2 = 52;

  // Register indexes
  localparam logic [CFG_W-1:0] REG_BOX_X  = 3'd0;
  localparam logic [CFG_W-1:0] REG_BOX_Y  = 3'd1;
  localparam logic [CFG_W-1:0] REG_BOX_Z  = 3'd2;
  localparam logic [CFG_W-1:0] REG_CELL_X = 3'd3;
  localparam logic [CFG_W-1:0] REG_CELL_Y = 3'd4;
  localparam logic [CFG_W-1:0] REG_CELL_Z = 3'd5;
  localparam logic [CFG_W-1:0] REG_ROW    = 3'd6;
  localparam logic [CFG_W-1:0] REG_PLANE  = 3'd7;

  // Operation codes
  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_BIN   = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_OFF_MEMB   = 3'd1;
  localparam logic [STAT_W-1:0] ST_OUT_Z      = 3'd2;
  localparam logic [STAT_W-1:0] ST_OUT_Y      = 3'd3;
  localparam logic [STAT_W-1:0] ST_OUT_X      = 3'd4;
  localparam logic [STAT_W-1:0] ST_CELL_RANGE = 3'd5;
  localparam logic [STAT_W-1:0] ST_CELL_FULL  = 3'd6;

  // Sequencer states
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL_GO,
    S_MUL_WAIT,
    S_SUM,
    S_RANGE,
    S_READ,
    S_UPDATE,
    S_CLEAR,
    S_DONE
  } state_t;

  // Status returned by a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Control of the count memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctrl_t;

endpackage

/* hw/rtl/cell_list_binning.sv */
// ----------------------------------------------------------------------------
// cell_list_binning
// Bins particles into the cells of a 3-D grid centered on the origin.
// ----------------------------------------------------------------------------
// One request is worked on at a time. A bin request first passes the
// membrane and box checks. Three divisions then run on one shared bit-serial
// divider, each made of a start, 24 quotient bits and a done step. Three
// multiplies follow on one shared shift-add multiplier. Then come the sum,
// the range check and the read-modify-write of the cell count, and the
// result is loaded. A request that fails a membrane, box or cell length check
// skips the rest and gives its result after the checks. One that lands
// outside the cell range gives it after the range check. A clear request
// sweeps the count memory at one cell a cycle and then gives its result.
// The next request is taken in the cycle after the result is loaded. After
// reset the same clearing pass runs over every cell before the first request
// is taken. Configuration writes are taken at any time. A finished result
// waits in an output register, so the next request can enter while it is
// still stalled.
module cell_list_binning #(
  parameter int unsigned NUM_CELLS    = 4096,
  parameter int unsigned MAX_PER_CELL = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [clb_pkg::CFG_W-1:0]           cfg_index,
  input  logic [clb_pkg::LEN_W-1:0]           cfg_data,
  // Request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                operation,
  input  logic [clb_pkg::ID_W-1:0]            particle_id,
  input  logic signed [clb_pkg::POS_W-1:0]    pos_x,
  input  logic signed [clb_pkg::POS_W-1:0]    pos_y,
  input  logic signed [clb_pkg::POS_W-1:0]    pos_z,
  input  logic                                fixed_in_z,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [clb_pkg::STAT_W-1:0]          status,
  output logic [clb_pkg::CELL_W-1:0]          cell_index,
  output logic [clb_pkg::SLOT_W-1:0]          slot_index,
  output logic [clb_pkg::ID_W-1:0]            echo_id
);

  localparam int unsigned AW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_PER_CELL + 1);
  localparam int unsigned CMPW = clb_pkg::CMP_W;
  localparam int unsigned DW   = clb_pkg::DIV_W;
  localparam int unsigned QW   = clb_pkg::QS_W;
  localparam int unsigned MAW  = clb_pkg::MA_W;
  localparam int unsigned MPW  = clb_pkg::MP_W;
  localparam int unsigned SW   = clb_pkg::SUM_W;
  localparam int unsigned LW   = clb_pkg::LEN_W;
  localparam int unsigned GW   = clb_pkg::GRID_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [LW-1:0] box_x, box_y, box_z;
  logic [LW-1:0] clen_x, clen_y, clen_z;
  logic [GW-1:0] row_len, plane_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x     <= LW'(25600);
      box_y     <= LW'(25600);
      box_z     <= LW'(25600);
      clen_x    <= LW'(1600);
      clen_y    <= LW'(1600);
      clen_z    <= LW'(1600);
      row_len   <= GW'(16);
      plane_len <= GW'(16);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        clb_pkg::REG_BOX_X:  box_x     <= cfg_data;
        clb_pkg::REG_BOX_Y:  box_y     <= cfg_data;
        clb_pkg::REG_BOX_Z:  box_z     <= cfg_data;
        clb_pkg::REG_CELL_X: clen_x    <= cfg_data;
        clb_pkg::REG_CELL_Y: clen_y    <= cfg_data;
        clb_pkg::REG_CELL_Z: clen_z    <= cfg_data;
        clb_pkg::REG_ROW:    row_len   <= cfg_data[GW-1:0];
        clb_pkg::REG_PLANE:  plane_len <= cfg_data[GW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request registers
  // --------------------------------------------------------------------------
  logic                   req_op;
  logic [clb_pkg::ID_W-1:0] req_id;
  logic signed [CMPW-1:0] x2, y2, z2;
  logic                   req_fixed;

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  clb_pkg::state_t state, state_next;
  logic [1:0]      axis, axis_next;
  logic [1:0]      mstep, mstep_next;
  logic [AW-1:0]   sweep, sweep_next;

  logic [clb_pkg::STAT_W-1:0] res_stat, res_stat_next;
  logic [clb_pkg::SLOT_W-1:0] res_slot, res_slot_next;
  logic                       res_use_cell, res_use_cell_next;

  // Numerators and quotients per axis
  logic [DW-1:0]          num_x, num_y, num_z;
  logic                   m1_x, m1_y, m1_z;
  logic signed [QW-1:0]   qx, qy, qz;
  logic signed [MPW-1:0]  prod_yr, prod_zr, prod_zrp;
  logic signed [SW-1:0]   cell_sum;

  // --------------------------------------------------------------------------
  // Box and membrane checks, doubled scale
  // --------------------------------------------------------------------------
  logic signed [CMPW-1:0] bxe, bye, bze;
  logic signed [CMPW-1:0] nx, ny, nz;
  logic                   memb_fail, out_z, out_y, out_x, zero_len;

  assign bxe = CMPW'({1'b0, box_x});
  assign bye = CMPW'({1'b0, box_y});
  assign bze = CMPW'({1'b0, box_z});

  assign memb_fail = req_fixed &&
                     (z2 - CMPW'(clb_pkg::MEMB_TOL2) + bze > CMPW'(0));
  assign out_z = (z2 > bze) || (z2 + CMPW'(2) + bze < CMPW'(0));
  assign out_y = (y2 > bye) || (y2 + CMPW'(2) + bye < CMPW'(0));
  assign out_x = (x2 > bxe) || (x2 + CMPW'(2) + bxe < CMPW'(0));
  assign zero_len = (clen_x == '0) || (clen_y == '0) || (clen_z == '0);

  assign nx = x2 + bxe;
  assign ny = y2 + bye;
  assign nz = bze - z2 - CMPW'(2);

  // --------------------------------------------------------------------------
  // Shared divider
  // --------------------------------------------------------------------------
  logic                div_start;
  logic [DW-1:0]       div_num, div_den, div_quot;
  clb_pkg::unit_stat_t div_stat;
  logic                div_m1;

  always_comb begin
    unique case (axis)
      2'd0: begin div_num = num_x; div_den = {clen_x, 1'b0}; div_m1 = m1_x; end
      2'd1: begin div_num = num_y; div_den = {clen_y, 1'b0}; div_m1 = m1_y; end
      default: begin
        div_num = num_z; div_den = {clen_z, 1'b0}; div_m1 = m1_z;
      end
    endcase
  end

  clb_serial_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // A numerator of -2 over a divisor of 2 truncates to -1
  logic signed [QW-1:0] q_signed;
  assign q_signed = div_m1 ? '1 : $signed({1'b0, div_quot});

  // --------------------------------------------------------------------------
  // Shared multiplier
  // --------------------------------------------------------------------------
  logic                  mul_start;
  logic signed [MAW-1:0] mul_a;
  logic [GW-1:0]         mul_b;
  logic signed [MPW-1:0] mul_prod;
  clb_pkg::unit_stat_t   mul_stat;

  always_comb begin
    unique case (mstep)
      2'd0: begin mul_a = {{(MAW-QW){qy[QW-1]}}, qy}; mul_b = row_len; end
      2'd1: begin mul_a = {{(MAW-QW){qz[QW-1]}}, qz}; mul_b = row_len; end
      default: begin mul_a = prod_zr[MAW-1:0]; mul_b = plane_len; end
    endcase
  end

  clb_serial_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  // --------------------------------------------------------------------------
  // Count memory
  // --------------------------------------------------------------------------
  clb_pkg::mem_ctrl_t mem_ctrl;
  logic [AW-1:0]      mem_addr;
  logic [CNTW-1:0]    mem_wdata, mem_rdata;
  logic [AW-1:0]      cell_addr;

  assign cell_addr = cell_sum[AW-1:0];

  clb_count_mem #(
    .DEPTH (NUM_CELLS),
    .AW    (AW),
    .DW    (CNTW)
  ) u_mem (
    .clk     (clk),
    .ctrl    (mem_ctrl),
    .addr    (mem_addr),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic out_free;
  logic out_load;
  logic in_take;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != clb_pkg::S_IDLE);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= clb_pkg::S_INIT;
      axis         <= '0;
      mstep        <= '0;
      sweep        <= '0;
      res_stat     <= clb_pkg::ST_OK;
      res_slot     <= '0;
      res_use_cell <= 1'b0;
    end else begin
      state        <= state_next;
      axis         <= axis_next;
      mstep        <= mstep_next;
      sweep        <= sweep_next;
      res_stat     <= res_stat_next;
      res_slot     <= res_slot_next;
      res_use_cell <= res_use_cell_next;
    end
  end

  always_comb begin
    state_next        = state;
    axis_next         = axis;
    mstep_next        = mstep;
    sweep_next        = sweep;
    res_stat_next     = res_stat;
    res_slot_next     = res_slot;
    res_use_cell_next = res_use_cell;
    div_start         = 1'b0;
    mul_start         = 1'b0;
    mem_ctrl.rd_en    = 1'b0;
    mem_ctrl.wr_en    = 1'b0;
    mem_addr          = cell_addr;
    mem_wdata         = '0;
    out_load          = 1'b0;

    unique case (state)
      // Clearing pass after reset
      clb_pkg::S_INIT: begin
        mem_ctrl.wr_en = 1'b1;
        mem_addr       = sweep;
        sweep_next     = sweep + 1'b1;
        if (sweep == AW'(NUM_CELLS - 1)) begin
          sweep_next = '0;
          state_next = clb_pkg::S_IDLE;
        end
      end

      clb_pkg::S_IDLE: begin
        res_stat_next     = clb_pkg::ST_OK;
        res_slot_next     = '0;
        res_use_cell_next = 1'b0;
        if (in_take) begin
          if (operation == clb_pkg::OP_CLEAR) begin
            sweep_next = '0;
            state_next = clb_pkg::S_CLEAR;
          end else begin
            state_next = clb_pkg::S_CHECK;
          end
        end
      end

      clb_pkg::S_CLEAR: begin
        mem_ctrl.wr_en = 1'b1;
        mem_addr       = sweep;
        sweep_next     = sweep + 1'b1;
        if (sweep == AW'(NUM_CELLS - 1)) begin
          sweep_next = '0;
          state_next = clb_pkg::S_DONE;
        end
      end

      // Membrane, box and cell length checks in priority order
      clb_pkg::S_CHECK: begin
        axis_next = 2'd0;
        priority if (memb_fail) begin
          res_stat_next = clb_pkg::ST_OFF_MEMB;
          state_next    = clb_pkg::S_DONE;
        end else if (out_z) begin
          res_stat_next = clb_pkg::ST_OUT_Z;
          state_next    = clb_pkg::S_DONE;
        end else if (out_y) begin
          res_stat_next = clb_pkg::ST_OUT_Y;
          state_next    = clb_pkg::S_DONE;
        end else if (out_x) begin
          res_stat_next = clb_pkg::ST_OUT_X;
          state_next    = clb_pkg::S_DONE;
        end else if (zero_len) begin
          res_stat_next = clb_pkg::ST_CELL_RANGE;
          state_next    = clb_pkg::S_DONE;
        end else begin
          state_next = clb_pkg::S_DIV_GO;
        end
      end

      clb_pkg::S_DIV_GO: begin
        div_start  = 1'b1;
        state_next = clb_pkg::S_DIV_WAIT;
      end

      clb_pkg::S_DIV_WAIT: begin
        if (div_stat.done) begin
          if (axis == 2'd2) begin
            mstep_next = 2'd0;
            state_next = clb_pkg::S_MUL_GO;
          end else begin
            axis_next  = axis + 1'b1;
            state_next = clb_pkg::S_DIV_GO;
          end
        end
      end

      clb_pkg::S_MUL_GO: begin
        mul_start  = 1'b1;
        state_next = clb_pkg::S_MUL_WAIT;
      end

      clb_pkg::S_MUL_WAIT: begin
        if (mul_stat.done) begin
          if (mstep == 2'd2) begin
            state_next = clb_pkg::S_SUM;
          end else begin
            mstep_next = mstep + 1'b1;
            state_next = clb_pkg::S_MUL_GO;
          end
        end
      end

      clb_pkg::S_SUM: begin
        state_next = clb_pkg::S_RANGE;
      end

      clb_pkg::S_RANGE: begin
        if (cell_sum < SW'(0) || cell_sum > $signed(SW'(NUM_CELLS - 1))) begin
          res_stat_next = clb_pkg::ST_CELL_RANGE;
          state_next    = clb_pkg::S_DONE;
        end else begin
          state_next = clb_pkg::S_READ;
        end
      end

      clb_pkg::S_READ: begin
        mem_ctrl.rd_en = 1'b1;
        state_next     = clb_pkg::S_UPDATE;
      end

      // Count read-modify-write
      clb_pkg::S_UPDATE: begin
        res_use_cell_next = 1'b1;
        if (mem_rdata >= CNTW'(MAX_PER_CELL)) begin
          res_stat_next = clb_pkg::ST_CELL_FULL;
        end else begin
          mem_ctrl.wr_en = 1'b1;
          mem_wdata      = mem_rdata + 1'b1;
          res_slot_next  = clb_pkg::SLOT_W'(mem_rdata);
        end
        state_next = clb_pkg::S_DONE;
      end

      clb_pkg::S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = clb_pkg::S_IDLE;
        end
      end

      default: state_next = clb_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // Capture the request at doubled scale
    if (in_take) begin
      req_op    <= operation;
      req_id    <= particle_id;
      x2        <= CMPW'($signed({pos_x, 1'b0}));
      y2        <= CMPW'($signed({pos_y, 1'b0}));
      z2        <= CMPW'($signed({pos_z, 1'b0}));
      req_fixed <= fixed_in_z;
    end
    // Numerators, clamped at zero, with the minus-one case noted
    if (state == clb_pkg::S_CHECK) begin
      num_x <= nx[CMPW-1] ? '0 : nx[DW-1:0];
      num_y <= ny[CMPW-1] ? '0 : ny[DW-1:0];
      num_z <= nz[CMPW-1] ? '0 : nz[DW-1:0];
      m1_x  <= (nx == -CMPW'(2)) && (clen_x == LW'(1));
      m1_y  <= (ny == -CMPW'(2)) && (clen_y == LW'(1));
      m1_z  <= (nz == -CMPW'(2)) && (clen_z == LW'(1));
    end
    if (state == clb_pkg::S_DIV_WAIT && div_stat.done) begin
      unique case (axis)
        2'd0:    qx <= q_signed;
        2'd1:    qy <= q_signed;
        default: qz <= q_signed;
      endcase
    end
    if (state == clb_pkg::S_MUL_WAIT && mul_stat.done) begin
      unique case (mstep)
        2'd0:    prod_yr  <= mul_prod;
        2'd1:    prod_zr  <= mul_prod;
        default: prod_zrp <= mul_prod;
      endcase
    end
    if (state == clb_pkg::S_SUM) begin
      cell_sum <= SW'(qx) + SW'(prod_yr) + SW'(prod_zrp);
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status     <= res_stat;
      cell_index <= (res_use_cell && req_op == clb_pkg::OP_BIN) ?
                    clb_pkg::CELL_W'(cell_sum) : '0;
      slot_index <= res_slot;
      echo_id    <= req_id;
    end
  end

endmodule

/* hw/rtl/clb_serial_div.sv */
// ----------------------------------------------------------------------------
// clb_serial_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module clb_serial_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [clb_pkg::DIV_W-1:0]   num,
  input  logic [clb_pkg::DIV_W-1:0]   den,
  output logic [clb_pkg::DIV_W-1:0]   quot,
  output clb_pkg::unit_stat_t         stat
);

  localparam int unsigned W  = clb_pkg::DIV_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  nq;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  // Shift in the next numerator bit and try a subtract
  assign rem_sh = {rem, nq[W-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and numerator/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      nq  <= num;
      dvs <= den;
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        nq  <= {nq[W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[W-1:0];
        nq  <= {nq[W-2:0], 1'b0};
      end
    end
  end

  assign quot      = nq;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* hw/rtl/clb_serial_mul.sv */
// ----------------------------------------------------------------------------
// clb_serial_mul
// Shift-add multiplier: signed multiplicand, unsigned multiplier, one
// multiplier bit per cycle.
// ----------------------------------------------------------------------------
module clb_serial_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [clb_pkg::MA_W-1:0]   a,
  input  logic [clb_pkg::GRID_W-1:0]        b,
  output logic signed [clb_pkg::MP_W-1:0]   prod,
  output clb_pkg::unit_stat_t               stat
);

  localparam int unsigned BW = clb_pkg::GRID_W;
  localparam int unsigned PW = clb_pkg::MP_W;
  localparam int unsigned AW = clb_pkg::MA_W;
  localparam int unsigned CW = $clog2(BW + 1);

  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] a_sh;
  logic [BW-1:0]        b_sh;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic                 done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(BW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_sh <= {{(PW-AW){a[AW-1]}}, a};
      b_sh <= b;
    end else if (busy) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= {a_sh[PW-2:0], 1'b0};
      b_sh <= {1'b0, b_sh[BW-1:1]};
    end
  end

  assign prod      = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* hw/rtl/clb_count_mem.sv */
// ----------------------------------------------------------------------------
// clb_count_mem
// Per-cell count memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module clb_count_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 7
) (
  input  logic                clk,
  input  clb_pkg::mem_ctrl_t  ctrl,
  input  logic [AW-1:0]       addr,
  input  logic [DW-1:0]       wr_data,
  output logic [DW-1:0]       rd_data
);

  logic [DW-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule
